// ===== sv/srbdf_pkg.sv =====
// ----------------------------------------------------------------------------
// srbdf_pkg
// Shared types and codes of the stereo ring buffer DAC feeder.
// ----------------------------------------------------------------------------
package srbdf_pkg;

    // Default frame store depth
    localparam int DEF_MAX_FRAMES = 1024;

    // Field widths
    localparam int SLOT_W     = 10;
    localparam int SAMPLE_W   = 16;
    localparam int FRAMES_W   = 11;
    localparam int INTERVAL_W = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAME_W    = 2 * SAMPLE_W;

    // Item modes
    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_SET_STOP = 2'd1;
    localparam logic [1:0] MODE_REQUEST  = 2'd2;
    localparam logic [1:0] MODE_RESTART  = 2'd3;

    // Channel code for the first sample; anything else is the second
    localparam logic [1:0] CHAN_FIRST = 2'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_FRAMES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALLBACK_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYING           = 2'd2;

    // Reset values of the registers
    localparam logic [FRAMES_W-1:0] RST_BUFFER_FRAMES = 11'd1024;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [1:0]                 channel;
        logic [SLOT_W-1:0]          slot;
        logic                       stop_armed;
        logic signed [SAMPLE_W-1:0] first_sample;
        logic signed [SAMPLE_W-1:0] second_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] dac_value;
        logic                       notify;
        logic [SLOT_W-1:0]          play_slot;
        logic                       at_stop;
    } out_item_t;

    // Control result handed from the sequencer to the output stage
    typedef struct packed {
        logic              active;
        logic              use_high;
        logic              notify;
        logic [SLOT_W-1:0] play_slot;
        logic              at_stop;
    } ctrl_res_t;

endpackage

// ===== sv/srbdf_frame_mem.sv =====
// ----------------------------------------------------------------------------
// srbdf_frame_mem
// Stereo frame store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srbdf_frame_mem
    import srbdf_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int IDX_W      = $clog2(MAX_FRAMES)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [FRAME_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [FRAME_W-1:0] rd_data
);

    logic [FRAME_W-1:0] mem [MAX_FRAMES];
    logic [FRAME_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/srbdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// srbdf_ctrl
// Configuration registers, play/stop pointers and notify countdown.
// ----------------------------------------------------------------------------
module srbdf_ctrl
    import srbdf_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int IDX_W      = $clog2(MAX_FRAMES)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 step,
    input  in_item_t             item,
    output logic                 mem_wr_en,
    output logic [IDX_W-1:0]     mem_wr_addr,
    output logic [FRAME_W-1:0]   mem_wr_data,
    output logic                 mem_rd_en,
    output logic [IDX_W-1:0]     mem_rd_addr,
    output ctrl_res_t            res
);

    // Compare width covers the index, the slot field and the frame count
    localparam int CW = ((IDX_W > FRAMES_W) ? IDX_W : FRAMES_W) + 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_FRAMES - 1);
    localparam logic [CW-1:0] DEPTH    = CW'(MAX_FRAMES);

    logic [FRAMES_W-1:0]   buffer_frames_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic                  playing_reg;
    logic [IDX_W-1:0]      play_reg, play_next;
    logic [SLOT_W-1:0]     stop_reg, stop_next;
    logic                  stop_valid_reg, stop_valid_next;
    logic [INTERVAL_W-1:0] count_reg, count_next;

    logic [CW-1:0]       slot_ext;
    logic [CW-1:0]       stop_ext;
    logic [CW-1:0]       play_next_ext;
    logic [FRAMES_W-1:0] wrap_at;
    logic [IDX_W-1:0]    play_adv;
    logic                at_stop_cur;
    logic                at_stop_adv;
    logic                active;
    logic                use_high;
    logic                notify;

    assign slot_ext     = CW'(item.slot);
    assign stop_ext     = CW'(stop_reg);
    assign at_stop_cur  = stop_valid_reg && (CW'(play_reg) == stop_ext);
    assign wrap_at      = buffer_frames_reg - FRAMES_W'(1);

    // Item processing
    always_comb begin
        play_next       = play_reg;
        stop_next       = stop_reg;
        stop_valid_next = stop_valid_reg;
        count_next      = count_reg;
        active          = 1'b0;
        use_high        = 1'b0;
        notify          = 1'b0;
        play_adv        = play_reg;
        at_stop_adv     = at_stop_cur;
        mem_wr_en       = 1'b0;
        case (item.mode)
            MODE_LOAD: begin
                mem_wr_en = step && (slot_ext < DEPTH);
            end
            MODE_SET_STOP: begin
                stop_next       = item.slot;
                stop_valid_next = item.stop_armed;
            end
            MODE_RESTART: begin
                play_next       = '0;
                stop_valid_next = 1'b0;
            end
            MODE_REQUEST: begin
                active   = playing_reg && !at_stop_cur;
                use_high = (item.channel != CHAN_FIRST);
                if (active && use_high) begin
                    play_adv = (CW'(play_reg) == LAST_IDX) ? '0 : play_reg + IDX_W'(1);
                end
                at_stop_adv = stop_valid_reg && (CW'(play_adv) == stop_ext);
                // notify countdown judged on the advanced slot
                if ((interval_reg != '0) && playing_reg && !at_stop_adv) begin
                    if (count_reg == '0) begin
                        notify     = 1'b1;
                        count_next = interval_reg - INTERVAL_W'(1);
                    end else begin
                        count_next = count_reg - INTERVAL_W'(1);
                    end
                end
                // buffer wrap applied last
                play_next = (CW'(play_adv) == CW'(wrap_at)) ? '0 : play_adv;
            end
            default: begin
                play_next = play_reg;
            end
        endcase
    end

    assign play_next_ext = CW'(play_next);

    // Memory ports
    assign mem_wr_addr = slot_ext[IDX_W-1:0];
    assign mem_wr_data = {item.second_sample, item.first_sample};
    assign mem_rd_en   = step;
    assign mem_rd_addr = play_reg;

    // Result fields for the output stage
    always_comb begin
        res.active    = active;
        res.use_high  = use_high;
        res.notify    = notify;
        res.play_slot = play_next_ext[SLOT_W-1:0];
        res.at_stop   = stop_valid_next && (play_next_ext == CW'(stop_next));
    end

    // State and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_frames_reg <= RST_BUFFER_FRAMES;
            interval_reg      <= '0;
            playing_reg       <= 1'b0;
            play_reg          <= '0;
            stop_reg          <= '0;
            stop_valid_reg    <= 1'b0;
            count_reg         <= '0;
        end else begin
            if (step) begin
                play_reg       <= play_next;
                stop_reg       <= stop_next;
                stop_valid_reg <= stop_valid_next;
                count_reg      <= count_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BUFFER_FRAMES: begin
                        buffer_frames_reg <= cfg_wdata[FRAMES_W-1:0];
                    end
                    CFG_CALLBACK_INTERVAL: begin
                        interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                        count_reg    <= '0;
                    end
                    CFG_PLAYING: begin
                        playing_reg <= cfg_wdata[0];
                    end
                    default: begin
                        playing_reg <= playing_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/stereo_ring_buffer_dac_feeder_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_ring_buffer_dac_feeder_unit
// Playback ring buffer of stereo frames feeding a DAC, one item per cycle while the result side is ready.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, sustained, with both sides free.
// Pipeline: an item passes the input register, then the result register,
//   loaded together with the registered read port of the frame store.
// Reset: synchronous, active low; pointers, stop, countdown and registers
//   take their reset values; the frame store is not cleared.
module stereo_ring_buffer_dac_feeder_unit
    import srbdf_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item
);

    localparam int IDX_W = $clog2(MAX_FRAMES);

    logic               a_valid_reg, a_valid_next;
    in_item_t           a_item_reg;
    logic               out_valid_reg, out_valid_next;
    ctrl_res_t          res_reg;
    ctrl_res_t          res;
    logic               advance;
    logic               s_xfer;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [FRAME_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [FRAME_W-1:0] mem_rd_data;

    // Pipeline flow
    assign advance = a_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !a_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_xfer) begin
            a_valid_next = 1'b1;
        end else if (advance) begin
            a_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            a_item_reg <= s_item;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    srbdf_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .step        (advance),
        .item        (a_item_reg),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .res         (res)
    );

    srbdf_frame_mem #(
        .MAX_FRAMES (MAX_FRAMES),
        .IDX_W      (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Sample select from the registered frame
    assign m_valid = out_valid_reg;
    always_comb begin
        if (!res_reg.active) begin
            m_item.dac_value = '0;
        end else if (res_reg.use_high) begin
            m_item.dac_value = mem_rd_data[FRAME_W-1:SAMPLE_W];
        end else begin
            m_item.dac_value = mem_rd_data[SAMPLE_W-1:0];
        end
        m_item.notify    = res_reg.notify;
        m_item.play_slot = res_reg.play_slot;
        m_item.at_stop   = res_reg.at_stop;
    end

    // Checks
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !out_valid_reg |-> advance)
        else $error("item stuck with free output stage");

    a_wr_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> advance && (a_item_reg.mode == MODE_LOAD))
        else $error("frame write outside a load transfer");

    a_sample_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.dac_value != '0) |-> res_reg.active)
        else $error("nonzero sample on an inactive result");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced item did not reach the output");

endmodule

// ===== verif/stereo_ring_buffer_dac_feeder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_ring_buffer_dac_feeder_unit_test
// Self-checking bench for the stereo playback ring buffer. Items go in over
// a valid/ready channel with bursty gaps while the result side stalls on its
// own patterns. An item-level model of the buffer predicts every result, and
// each result transfer is checked field by field. Directed cases come first,
// then a long result-side hold and register sweeps, both with random traffic.
// ----------------------------------------------------------------------------
module stereo_ring_buffer_dac_feeder_unit_test;
    import srbdf_pkg::*;

    localparam int  HALF_PERIOD    = 10;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  HOLD_CYCLES    = 120;
    localparam int  PHASE_ITEMS    = 105;
    localparam int  STORE_DEPTH    = DEF_MAX_FRAMES;

    // Channel codes besides the first; 0 and 3 behave as the second
    localparam logic [1:0] CHAN_SECOND  = 2'd2;
    localparam logic [1:0] CHAN_ALT_LOW = 2'd0;
    localparam logic [1:0] CHAN_ALT_TOP = 2'd3;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_item_t         s_item = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_item_t        m_item;

    stereo_ring_buffer_dac_feeder_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // Clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Buffer model state
    // ------------------------------------------------------------------
    logic [FRAME_W-1:0]    frame_mem [STORE_DEPTH];
    bit                    frame_loaded [STORE_DEPTH];
    logic [SLOT_W-1:0]     play_idx = '0;
    logic [SLOT_W-1:0]     stop_idx = '0;
    logic                  stop_on = 1'b0;
    logic [INTERVAL_W-1:0] countdown = '0;
    logic [FRAMES_W-1:0]   frames_in_use = RST_BUFFER_FRAMES;
    logic [INTERVAL_W-1:0] interval = '0;
    logic                  play_on = 1'b0;

    out_item_t due_results [$];

    int n_items = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_notify = 0;
    int n_played = 0;
    int n_parked = 0;
    int burst_left = 0;
    int hold_token = 0;

    function automatic logic parked();
        return stop_on && (play_idx == stop_idx);
    endfunction

    // Applies one item to the model and returns the result it produces
    function automatic out_item_t next_dac_result(input in_item_t it);
        out_item_t r;
        logic [FRAME_W-1:0] frame;
        r = '0;
        case (it.mode)
            MODE_LOAD: begin
                frame_mem[it.slot] = {it.second_sample, it.first_sample};
                frame_loaded[it.slot] = 1'b1;
            end
            MODE_SET_STOP: begin
                stop_idx = it.slot;
                stop_on  = it.stop_armed;
            end
            MODE_RESTART: begin
                play_idx = '0;
                stop_on  = 1'b0;
            end
            MODE_REQUEST: begin
                if (play_on && !parked()) begin
                    frame = frame_mem[play_idx];
                    n_played++;
                    if (it.channel == CHAN_FIRST) begin
                        r.dac_value = frame[SAMPLE_W-1:0];
                    end else begin
                        r.dac_value = frame[FRAME_W-1:SAMPLE_W];
                        play_idx = play_idx + 1'b1;
                    end
                end else if (parked()) begin
                    n_parked++;
                end
                // notify is judged on the slot after advancing, before the wrap
                if (interval != 0 && play_on && !parked()) begin
                    if (countdown == 0) begin
                        r.notify  = 1'b1;
                        countdown = interval;
                    end
                    countdown = countdown - 1'b1;
                end
                if ({1'b0, play_idx} == frames_in_use - 1'b1) begin
                    play_idx = '0;
                end
            end
            default: ;
        endcase
        r.play_slot = play_idx;
        r.at_stop   = parked();
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t mk_item(input logic [1:0] mode, input logic [1:0] chan,
                                         input int slot, input logic armed,
                                         input int first, input int second);
        in_item_t it;
        it.mode          = mode;
        it.channel       = chan;
        it.slot          = SLOT_W'(slot);
        it.stop_armed    = armed;
        it.first_sample  = SAMPLE_W'(first);
        it.second_sample = SAMPLE_W'(second);
        return it;
    endfunction

    // Random item biased toward playback: requests mostly, loads and stops
    // near the play slot so the stop gets hit and wraps happen
    function automatic in_item_t pick_item();
        in_item_t it;
        int w;
        int c;
        w = $urandom_range(0, 99);
        it.channel       = 2'($urandom);
        it.slot          = SLOT_W'($urandom);
        it.stop_armed    = 1'($urandom);
        it.first_sample  = rand_sample();
        it.second_sample = rand_sample();
        if (w < 62) begin
            it.mode = MODE_REQUEST;
            c = $urandom_range(0, 19);
            if (c < 9)
                it.channel = CHAN_FIRST;
            else if (c < 18)
                it.channel = CHAN_SECOND;
            else
                it.channel = $urandom_range(0, 1) ? CHAN_ALT_LOW : CHAN_ALT_TOP;
        end else if (w < 82) begin
            it.mode = MODE_LOAD;
            if ($urandom_range(0, 1))
                it.slot = play_idx + SLOT_W'($urandom_range(0, 7));
        end else if (w < 92) begin
            it.mode = MODE_SET_STOP;
            it.stop_armed = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 2) != 0)
                it.slot = play_idx + SLOT_W'($urandom_range(0, 6));
        end else begin
            it.mode = MODE_RESTART;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One transfer on the input channel, with bursts and random gaps
    task automatic drive_item(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_item  = it;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due_results.push_back(next_dac_result(it));
        n_items++;
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Never lets a request read a frame that was not loaded: fill it first
    task automatic send_item(input in_item_t it);
        in_item_t fill;
        if (it.mode == MODE_REQUEST && play_on && !parked() && !frame_loaded[play_idx]) begin
            fill = mk_item(MODE_LOAD, 2'($urandom), play_idx, 1'($urandom),
                           rand_sample(), rand_sample());
            drive_item(fill);
        end
        drive_item(it);
    endtask

    task automatic settle();
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        case (idx)
            CFG_BUFFER_FRAMES: frames_in_use = data[FRAMES_W-1:0];
            CFG_CALLBACK_INTERVAL: begin
                interval  = data;
                countdown = '0;
            end
            CFG_PLAYING: play_on = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(input int frames, input int ivl, input bit play);
        settle();
        cfg_write(CFG_BUFFER_FRAMES, CFG_W'(frames));
        cfg_write(CFG_CALLBACK_INTERVAL, CFG_W'(ivl));
        cfg_write(CFG_PLAYING, CFG_W'(play));
    endtask

    // ------------------------------------------------------------------
    // Result side: rotating stall patterns, plus a long hold on demand
    // ------------------------------------------------------------------
    int rx_cycle = 0;
    int rx_pattern = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) rx_pattern <= $urandom_range(0, 3);
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (rx_pattern)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 9) >= 3);
                2: m_ready <= (rx_cycle % 4 != 0);
                default: m_ready <= ((rx_cycle / 8) % 4 != 0);
            endcase
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
                 $time, n_results, what, got, want);
        n_errors++;
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, dac_value", m_item.dac_value, 0);
            end else begin
                want = due_results.pop_front();
                if (m_item.dac_value !== want.dac_value)
                    report_mismatch("dac_value", m_item.dac_value, want.dac_value);
                if (m_item.notify !== want.notify)
                    report_mismatch("notify", m_item.notify, want.notify);
                if (m_item.play_slot !== want.play_slot)
                    report_mismatch("play_slot", m_item.play_slot, want.play_slot);
                if (m_item.at_stop !== want.at_stop)
                    report_mismatch("at_stop", m_item.at_stop, want.at_stop);
                if (want.notify) n_notify++;
            end
            n_results++;
        end
    end

    // Watchdog: too long without any transfer ends the run
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("stereo_ring_buffer_dac_feeder_unit_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset state, not playing: requests give zero, slot extremes, stop flag
    task automatic test_idle_after_reset();
        send_item(mk_item(MODE_LOAD, CHAN_FIRST, 0, 1'b0, -32768, 32767));
        send_item(mk_item(MODE_LOAD, CHAN_SECOND, 1023, 1'b1, 32767, -32768));
        send_item(mk_item(MODE_REQUEST, CHAN_FIRST, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_SECOND, 1023, 1'b1, -1, -1));
        send_item(mk_item(MODE_SET_STOP, CHAN_FIRST, 0, 1'b1, 0, 0));
        send_item(mk_item(MODE_SET_STOP, CHAN_FIRST, 1023, 1'b0, 0, 0));
        send_item(mk_item(MODE_RESTART, CHAN_SECOND, 0, 1'b0, 0, 0));
    endtask

    // Three-frame loop: both channels, alias channel codes, wrap, notify,
    // stop reached by advancing, stop on the wrap slot, clear and restart
    task automatic test_playback_and_stop();
        apply_settings(3, 2, 1'b1);
        send_item(mk_item(MODE_LOAD, CHAN_FIRST, 0, 1'b0, 0, -1));
        send_item(mk_item(MODE_LOAD, CHAN_FIRST, 1, 1'b0, 'h1234, -'h1234));
        send_item(mk_item(MODE_LOAD, CHAN_FIRST, 2, 1'b0, -2, 2));
        send_item(mk_item(MODE_REQUEST, CHAN_FIRST, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_SECOND, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_ALT_LOW, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_ALT_TOP, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_FIRST, 0, 1'b0, 0, 0));
        // stop on the last slot: the wrap moves past it at once
        send_item(mk_item(MODE_SET_STOP, CHAN_FIRST, 2, 1'b1, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_SECOND, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_SET_STOP, CHAN_FIRST, 1, 1'b1, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_SECOND, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_SECOND, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_FIRST, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_SET_STOP, CHAN_FIRST, 1, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_SECOND, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_RESTART, CHAN_FIRST, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_REQUEST, CHAN_FIRST, 0, 1'b0, 0, 0));
    endtask

    // Result side held off while the sender keeps offering items
    task automatic test_backpressure();
        int i;
        apply_settings(8, 3, 1'b1);
        hold_token = hold_token + 1;
        burst_left = 64;
        for (i = 0; i < 48; i++) send_item(pick_item());
    endtask

    // Random traffic under a series of register settings, extremes included;
    // odd frame counts exercise the literal wrap compare
    task automatic test_register_sweep();
        int frames_set [9] = '{2, 1024, 5, 0, 1, 1025, 2047, 64, 2};
        int ivl_set [9]    = '{1, 0, 3, 65535, 7, 2, 1, 4, 1};
        bit play_set [9]   = '{1, 1, 1, 1, 0, 1, 1, 1, 1};
        int p;
        int i;
        frames_set[8] = $urandom_range(2, 1024);
        ivl_set[8]    = $urandom_range(1, 40);
        for (p = 0; p < 9; p++) begin
            apply_settings(frames_set[p], ivl_set[p], play_set[p]);
            for (i = 0; i < PHASE_ITEMS; i++) send_item(pick_item());
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_after_reset();
        test_playback_and_stop();
        test_backpressure();
        test_register_sweep();

        while (due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("covered %0d items and %0d results: %0d samples played, %0d requests",
                 n_items, n_results, n_played, n_parked);
        $display("held at the stop slot, %0d refill notifications, %0d mismatches",
                 n_notify, n_errors);
        if (n_errors == 0)
            $display("stereo_ring_buffer_dac_feeder_unit_test: PASS");
        else
            $display("stereo_ring_buffer_dac_feeder_unit_test: FAIL");
        $finish;
    end

endmodule

// ===== stereo_ring_buffer_dac_feeder_unit.f =====
sv/srbdf_pkg.sv
sv/srbdf_frame_mem.sv
sv/srbdf_ctrl.sv
sv/stereo_ring_buffer_dac_feeder_unit.sv
verif/stereo_ring_buffer_dac_feeder_unit_test.sv
